[hdl/hpbm_pkg.sv]
// shared constants for the histogram peak background mask block
package hpbm_pkg;

  // sizing
  localparam int MAX_BINS     = 128;
  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 24;
  localparam int BIN_BITS     = $clog2(MAX_BINS);
  localparam int NBIN_BITS    = BIN_BITS + 1;
  localparam int SUM_BITS     = COUNT_BITS + BIN_BITS;
  localparam int OUT_BIN_BITS = 7;

  // configuration register
  localparam int CFG_BITS = 8;
  localparam logic [CFG_BITS-1:0] BINS_RESET = CFG_BITS'(100);

  // command codes
  localparam int CMD_BITS = 3;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_RANGE    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_HIST     = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_WINDOW   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_CLASSIFY = 3'd4;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_MASK   = 1'b1;

  // range tracker reset values
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // saturated count value
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage

[hdl/histogram_peak_background_mask_core.sv]
// top level: multi-pass histogram peak background masker
//
// Usage: the volume is streamed through in passes, one command per transaction.
// A transaction is taken at a clock edge with start high and busy low.
// Commands: clear, range sample, histogram sample, find window, classify sample.
// Clear and range samples finish in the accept cycle; busy never rises.
// A histogram sample keeps busy high through a multiply state, eight
// restoring divide steps (one quotient bit per cycle), a bin ram read and
// the write back of the incremented count. Out-of-range samples skip busy.
// Find window scans the bin ram, a read and a compare per bin in use, then
// grows the window by one bin per step (two ram reads and a compare, one read
// at an edge); the single ram read port serializes the reads.
// Classify uses one shared multiplier (sample scale, low edge, high edge), then
// the result. With a flat range, window and classify results come in the cycle
// after accept without busy. Results appear on out_* for exactly one cycle
// marked by out_valid; the receiver cannot stall them. The user must write
// bins_in_use through cfg_we only while idle; the block does not enforce it.
// Reset clears the range, counts, total and window and sets bins_in_use to
// 100; bin counts are cleared through per-bin valid flops, so no clearing pass.
module histogram_peak_background_mask_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [hpbm_pkg::CMD_BITS-1:0]          in_command,
  input  logic signed [hpbm_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  output logic                                   out_result_kind,
  output logic                                   out_mask_bit,
  output logic [hpbm_pkg::OUT_BIN_BITS-1:0]      out_low_bin,
  output logic [hpbm_pkg::OUT_BIN_BITS-1:0]      out_high_bin,
  input  logic                                   cfg_we,
  input  logic [hpbm_pkg::CFG_BITS-1:0]          cfg_wdata
);

  import hpbm_pkg::*;

  localparam int QBITS     = NBIN_BITS;
  localparam int K_BITS    = (QBITS > 1) ? $clog2(QBITS) : 1;
  localparam int REM_BITS  = SAMPLE_BITS + QBITS;
  localparam int MUL_A_BITS = SAMPLE_BITS + 2;
  localparam int MUL_B_BITS = NBIN_BITS + 1;
  localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_H_MUL   = 15'b000000000000010,
    ST_H_DIV   = 15'b000000000000100,
    ST_H_ADR   = 15'b000000000001000,
    ST_H_UPD   = 15'b000000000010000,
    ST_W_SRD   = 15'b000000000100000,
    ST_W_SCMP  = 15'b000000001000000,
    ST_W_GROW  = 15'b000000010000000,
    ST_W_LEFT  = 15'b000000100000000,
    ST_W_RIGHT = 15'b000001000000000,
    ST_W_TAKE  = 15'b000010000000000,
    ST_C_M0    = 15'b000100000000000,
    ST_C_M1    = 15'b001000000000000,
    ST_C_M2    = 15'b010000000000000,
    ST_C_CMP   = 15'b100000000000000
  } state_t;

  // control state
  state_t                         state_r, state_nxt;
  logic [MAX_BINS-1:0]            valid_r, valid_nxt;
  logic [COUNT_BITS-1:0]          total_r, total_nxt;
  logic signed [SAMPLE_BITS-1:0]  min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0]  max_r, max_nxt;
  logic [BIN_BITS-1:0]            win_lo_r, win_lo_nxt;
  logic [BIN_BITS-1:0]            win_hi_r, win_hi_nxt;
  logic [CFG_BITS-1:0]            bins_r, bins_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // datapath registers
  logic signed [SAMPLE_BITS:0]    diff_r, diff_nxt;
  logic [SAMPLE_BITS-1:0]         span_r, span_nxt;
  logic signed [PROD_BITS-1:0]    prod_r;
  logic signed [PROD_BITS-1:0]    scaled_r, scaled_nxt;
  logic signed [PROD_BITS-1:0]    lowr_r, lowr_nxt;
  logic [REM_BITS-1:0]            rem_r, rem_nxt;
  logic [QBITS-1:0]               quot_r, quot_nxt;
  logic [K_BITS-1:0]              k_r, k_nxt;
  logic [BIN_BITS-1:0]            bin_r, bin_nxt;
  logic [BIN_BITS-1:0]            idx_r, idx_nxt;
  logic [COUNT_BITS-1:0]          peak_r, peak_nxt;
  logic [BIN_BITS-1:0]            pidx_r, pidx_nxt;
  logic [BIN_BITS-1:0]            lo_r, lo_nxt;
  logic [BIN_BITS-1:0]            hi_r, hi_nxt;
  logic [SUM_BITS-1:0]            sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]          left_r, left_nxt;
  logic                           dir_up_r, dir_up_nxt;
  logic [BIN_BITS-1:0]            rd_addr_r, rd_addr_nxt;
  logic                           out_kind_r, out_kind_nxt;
  logic                           out_mask_r, out_mask_nxt;
  logic [OUT_BIN_BITS-1:0]        out_low_r, out_low_nxt;
  logic [OUT_BIN_BITS-1:0]        out_high_r, out_high_nxt;

  // combinational helpers
  logic [NBIN_BITS-1:0]           n_bins;
  logic [BIN_BITS-1:0]            nm1;
  logic                           flat;
  logic [SAMPLE_BITS-1:0]         span_now;
  logic signed [SAMPLE_BITS:0]    sample_diff;
  logic signed [MUL_A_BITS-1:0]   mul_a;
  logic signed [MUL_B_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]    mul_p;
  logic [REM_BITS-1:0]            trial_den;
  logic [COUNT_BITS-1:0]          rd_cnt;
  logic                           win_inside;

  // bin count ram
  logic                           ram_we;
  logic [BIN_BITS-1:0]            ram_waddr;
  logic [COUNT_BITS-1:0]          ram_wdata;
  logic                           ram_re;
  logic [BIN_BITS-1:0]            ram_raddr;
  logic [COUNT_BITS-1:0]          ram_rdata;

  hpbm_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective bin count, saturated to 1..MAX_BINS
  always_comb begin
    if (bins_r == '0) begin
      n_bins = NBIN_BITS'(1);
    end else if (int'(bins_r) > MAX_BINS) begin
      n_bins = NBIN_BITS'(MAX_BINS);
    end else begin
      n_bins = NBIN_BITS'(bins_r);
    end
  end

  assign nm1         = BIN_BITS'(n_bins - 1'b1);
  assign flat        = (max_r <= min_r);
  assign span_now    = max_r - min_r;
  assign sample_diff = $signed({in_sample[SAMPLE_BITS-1], in_sample})
                     - $signed({min_r[SAMPLE_BITS-1], min_r});

  // ram read data, unwritten bins read as zero
  assign rd_cnt = valid_r[rd_addr_r] ? ram_rdata : '0;

  // divider trial subtrahend
  assign trial_den = REM_BITS'(span_r) << k_r;

  // classify window compare against the high edge product in prod_r
  assign win_inside = (scaled_r >= lowr_r) && (scaled_r <= prod_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = $signed({diff_r[SAMPLE_BITS], diff_r});
    mul_b = $signed({1'b0, n_bins});
    case (state_r)
      ST_C_M1: begin
        mul_a = $signed({2'b00, span_r});
        mul_b = $signed(MUL_B_BITS'(win_lo_r));
      end
      ST_C_M2: begin
        mul_a = $signed({2'b00, span_r});
        mul_b = $signed(MUL_B_BITS'(win_hi_r) + MUL_B_BITS'(1));
      end
      default: begin
        mul_a = $signed({diff_r[SAMPLE_BITS], diff_r});
        mul_b = $signed({1'b0, n_bins});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    total_nxt     = total_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    win_lo_nxt    = win_lo_r;
    win_hi_nxt    = win_hi_r;
    bins_nxt      = cfg_we ? cfg_wdata : bins_r;
    out_valid_nxt = 1'b0;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    scaled_nxt    = scaled_r;
    lowr_nxt      = lowr_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    k_nxt         = k_r;
    bin_nxt       = bin_r;
    idx_nxt       = idx_r;
    peak_nxt      = peak_r;
    pidx_nxt      = pidx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sum_nxt       = sum_r;
    left_nxt      = left_r;
    dir_up_nxt    = dir_up_r;
    out_kind_nxt  = out_kind_r;
    out_mask_nxt  = out_mask_r;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;
    ram_we        = 1'b0;
    ram_waddr     = bin_r;
    ram_wdata     = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_command)
            CMD_CLEAR: begin
              valid_nxt  = '0;
              total_nxt  = '0;
              min_nxt    = SAMPLE_TOP;
              max_nxt    = SAMPLE_BOTTOM;
              win_lo_nxt = '0;
              win_hi_nxt = '0;
            end
            CMD_RANGE: begin
              if (in_sample < min_r) begin
                min_nxt = in_sample;
              end
              if (in_sample > max_r) begin
                max_nxt = in_sample;
              end
            end
            CMD_HIST: begin
              if (!flat && in_sample >= min_r && in_sample <= max_r) begin
                diff_nxt  = sample_diff;
                span_nxt  = span_now;
                state_nxt = ST_H_MUL;
              end
            end
            CMD_WINDOW: begin
              if (flat) begin
                win_lo_nxt    = '0;
                win_hi_nxt    = '0;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_REPORT;
                out_mask_nxt  = 1'b0;
                out_low_nxt   = '0;
                out_high_nxt  = '0;
              end else begin
                idx_nxt   = '0;
                peak_nxt  = '0;
                pidx_nxt  = '0;
                state_nxt = ST_W_SRD;
              end
            end
            CMD_CLASSIFY: begin
              if (flat) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_MASK;
                out_mask_nxt  = 1'b0;
                out_low_nxt   = OUT_BIN_BITS'(win_lo_r);
                out_high_nxt  = OUT_BIN_BITS'(win_hi_r);
              end else begin
                diff_nxt  = sample_diff;
                span_nxt  = span_now;
                state_nxt = ST_C_M0;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // histogram: offset times bin count, then divide by the span
      ST_H_MUL: begin
        rem_nxt   = mul_p[REM_BITS-1:0];
        quot_nxt  = '0;
        k_nxt     = K_BITS'(QBITS - 1);
        state_nxt = ST_H_DIV;
      end
      ST_H_DIV: begin
        if (rem_r >= trial_den) begin
          rem_nxt       = rem_r - trial_den;
          quot_nxt[k_r] = 1'b1;
        end
        if (k_r == '0) begin
          state_nxt = ST_H_ADR;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      ST_H_ADR: begin
        bin_nxt   = (quot_r >= n_bins) ? nm1 : BIN_BITS'(quot_r);
        ram_re    = 1'b1;
        ram_raddr = bin_nxt;
        state_nxt = ST_H_UPD;
      end
      ST_H_UPD: begin
        ram_we           = 1'b1;
        valid_nxt[bin_r] = 1'b1;
        if (total_r != COUNT_MAX) begin
          total_nxt = total_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      // window: peak scan over the bins in use
      ST_W_SRD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = ST_W_SCMP;
      end
      ST_W_SCMP: begin
        if (rd_cnt > peak_r) begin
          peak_nxt = rd_cnt;
          pidx_nxt = idx_r;
        end
        if (idx_r == nm1) begin
          lo_nxt    = pidx_nxt;
          hi_nxt    = pidx_nxt;
          sum_nxt   = SUM_BITS'(peak_nxt);
          state_nxt = ST_W_GROW;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_W_SRD;
        end
      end

      // window: grow to the fuller side until it holds half the total or all bins
      ST_W_GROW: begin
        if ({sum_r, 1'b0} >= (SUM_BITS + 1)'(total_r) ||
            (lo_r == '0 && hi_r == nm1)) begin
          win_lo_nxt    = lo_r;
          win_hi_nxt    = hi_r;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REPORT;
          out_mask_nxt  = 1'b0;
          out_low_nxt   = OUT_BIN_BITS'(lo_r);
          out_high_nxt  = OUT_BIN_BITS'(hi_r);
          state_nxt     = ST_IDLE;
        end else if (lo_r == '0) begin
          ram_re     = 1'b1;
          ram_raddr  = hi_r + 1'b1;
          dir_up_nxt = 1'b1;
          state_nxt  = ST_W_TAKE;
        end else if (hi_r == nm1) begin
          ram_re     = 1'b1;
          ram_raddr  = lo_r - 1'b1;
          dir_up_nxt = 1'b0;
          state_nxt  = ST_W_TAKE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = lo_r - 1'b1;
          state_nxt = ST_W_LEFT;
        end
      end
      ST_W_LEFT: begin
        left_nxt  = rd_cnt;
        ram_re    = 1'b1;
        ram_raddr = hi_r + 1'b1;
        state_nxt = ST_W_RIGHT;
      end
      ST_W_RIGHT: begin
        if (left_r > rd_cnt) begin
          lo_nxt  = lo_r - 1'b1;
          sum_nxt = sum_r + SUM_BITS'(left_r);
        end else begin
          hi_nxt  = hi_r + 1'b1;
          sum_nxt = sum_r + SUM_BITS'(rd_cnt);
        end
        state_nxt = ST_W_GROW;
      end
      ST_W_TAKE: begin
        if (dir_up_r) begin
          hi_nxt = hi_r + 1'b1;
        end else begin
          lo_nxt = lo_r - 1'b1;
        end
        sum_nxt   = sum_r + SUM_BITS'(rd_cnt);
        state_nxt = ST_W_GROW;
      end

      // classify: scaled offset, low edge and high edge on the shared multiplier
      ST_C_M0: begin
        state_nxt = ST_C_M1;
      end
      ST_C_M1: begin
        scaled_nxt = prod_r;
        state_nxt  = ST_C_M2;
      end
      ST_C_M2: begin
        lowr_nxt  = prod_r;
        state_nxt = ST_C_CMP;
      end
      ST_C_CMP: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_MASK;
        out_mask_nxt  = !win_inside;
        out_low_nxt   = OUT_BIN_BITS'(win_lo_r);
        out_high_nxt  = OUT_BIN_BITS'(win_hi_r);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_addr_nxt = ram_re ? ram_raddr : rd_addr_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      min_r       <= SAMPLE_TOP;
      max_r       <= SAMPLE_BOTTOM;
      win_lo_r    <= '0;
      win_hi_r    <= '0;
      bins_r      <= BINS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      win_lo_r    <= win_lo_nxt;
      win_hi_r    <= win_hi_nxt;
      bins_r      <= bins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    span_r     <= span_nxt;
    prod_r     <= mul_p;
    scaled_r   <= scaled_nxt;
    lowr_r     <= lowr_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    k_r        <= k_nxt;
    bin_r      <= bin_nxt;
    idx_r      <= idx_nxt;
    peak_r     <= peak_nxt;
    pidx_r     <= pidx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sum_r      <= sum_nxt;
    left_r     <= left_nxt;
    dir_up_r   <= dir_up_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_kind_r <= out_kind_nxt;
    out_mask_r <= out_mask_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  // outputs
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_mask_bit    = out_mask_r;
  assign out_low_bin     = out_low_r;
  assign out_high_bin    = out_high_r;

  // divider quotient never exceeds the bin count
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_H_ADR |-> quot_r <= n_bins)
    else $error("histogram quotient above bin count");

  // count write lands on a bin in use
  a_write_bin: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> bin_r <= nm1)
    else $error("bin write outside bins in use");

  // growing window stays ordered and inside the bins in use
  a_grow_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_W_GROW |-> (lo_r <= hi_r && hi_r <= nm1))
    else $error("window bounds out of order");

  // every reported window is ordered
  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_low_r <= out_high_r)
    else $error("result window out of order");

endmodule

[hdl/hpbm_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
module hpbm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data registered on a read enable
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
